>>> sv/center_weighted_luminance_mean_macros.svh
// ----------------------------------------------------------------------------
// Center-weighted luminance mean: assertion macros
// Shared concurrent-assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef CENTER_WEIGHTED_LUMINANCE_MEAN_MACROS_SVH
`define CENTER_WEIGHTED_LUMINANCE_MEAN_MACROS_SVH

// same-cycle implication
`define CWLM_ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define CWLM_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> sv/cwlm_pkg.sv
// ----------------------------------------------------------------------------
// cwlm_pkg
// Constants, types, weight table and helpers of the luminance meter.
// ----------------------------------------------------------------------------
`default_nettype none

package cwlm_pkg;

   localparam int MAX_WIDTH          = 256;
   localparam int MAX_HEIGHT         = 256;
   localparam int WEIGHT_TABLE_DEPTH = 256;

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SIZE_W = 9;
   localparam int STEP_W = 16;
   localparam int PIX_W  = 16;
   localparam int OFF_W  = SIZE_W + 1;
   localparam int POS_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int CMP_W  = ((POS_MAX_W > SIZE_W) ? POS_MAX_W : SIZE_W) + 1;
   localparam int IDX_W  = $clog2(WEIGHT_TABLE_DEPTH);
   localparam int IDX_PROD_W = OFF_W + STEP_W;
   localparam int SCALED_W   = IDX_PROD_W + IDX_W + 1;
   localparam int WT_W   = 17;

   localparam int LUMA_PROD_W = 32;
   localparam int LUMA_SUM_W  = 34;
   localparam int LUMA_W      = 17;
   localparam int WPROD_W     = 2 * WT_W;
   localparam int LW_W        = LUMA_W + WT_W;
   localparam int SUM_W       = 48;
   localparam int NUM_W       = SUM_W + 4;
   localparam int DIV_CNT_W   = $clog2(NUM_W);
   localparam int Q_W         = 22;
   localparam int GAIN_W      = 17;
   localparam int GAIN_PROD_W = Q_W + GAIN_W;
   localparam int GROUND_W    = GAIN_PROD_W + 1;

   localparam logic [PIX_W-1:0]  LUMA_R    = 16'd13933;
   localparam logic [PIX_W-1:0]  LUMA_G    = 16'd46872;
   localparam logic [PIX_W-1:0]  LUMA_B    = 16'd4732;
   localparam logic [GAIN_W-1:0] GAIN_Q16  = 17'd68223;
   localparam logic [NUM_W-1:0]  Q_MAX     = NUM_W'(1) << 21;
   localparam logic [SUM_W-1:0]  SUM_MAX   = '1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_COLUMN_STEP  = 2'd2,
      CSR_ROW_STEP     = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_INDEX,
      ST_LOOKUP,
      ST_WMUL,
      ST_WROUND,
      ST_LWMUL,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIV,
      ST_GAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_pixel;
      logic calc_product;
      logic calc_index;
      logic read_table;
      logic mul_weight;
      logic round_weight;
      logic mul_luma;
      logic accumulate;
      logic div_load;
      logic div_step;
      logic calc_gain;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
   } status_type;

   typedef logic [WT_W-1:0] weight_table_type [WEIGHT_TABLE_DEPTH];

   // unsigned 64-bit quotient by shift and subtract; elaboration only
   function automatic logic [63:0] const_udiv64(input logic [63:0] num,
                                                input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(65536 * exp(-x)), x in Q36.28; elaboration only
   function automatic logic [WT_W-1:0] neg_exp_q16(input logic [63:0] xq);
      logic [63:0] whole;
      logic [63:0] frac;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      int i;
      whole = xq >> 28;
      frac  = (xq & ((64'd1 << 28) - 64'd1)) << 4;
      term  = 64'd1 << 32;
      sum   = term;
      for (i = 1; i <= 20; i++) begin
         term = const_udiv64((term * frac) >> 32, 64'(i));
         sum  = sum + term;
      end
      r = const_udiv64(64'd1 << 62, sum) << 2;
      for (i = 0; i < 32; i++) begin
         if (64'(i) < whole) begin
            r = (r * 64'd1580030169 + (64'd1 << 31)) >> 32;
         end
      end
      return WT_W'((r + (64'd1 << 15)) >> 16);
   endfunction

   function automatic weight_table_type build_weight_table();
      weight_table_type t;
      logic [63:0] xq;
      logic [63:0] d;
      int k;
      d = 64'(WEIGHT_TABLE_DEPTH);
      for (k = 0; k < WEIGHT_TABLE_DEPTH; k++) begin
         xq   = const_udiv64((64'd81 * 64'(k) * 64'(k)) << 28, 64'd4 * d * d);
         t[k] = neg_exp_q16(xq);
      end
      return t;
   endfunction

   localparam weight_table_type WEIGHT_TABLE = build_weight_table();

   // |2*pos - (size-1)|
   function automatic logic [OFF_W-1:0] doubled_offset(input logic [OFF_W-1:0] twice,
                                                       input logic [SIZE_W-1:0] size);
      logic [OFF_W-1:0] span;
      span = OFF_W'(size) - OFF_W'(1);
      return (twice >= span) ? (twice - span) : (span - twice);
   endfunction

   // (prod * depth) >> 16, saturated to the last table entry
   function automatic logic [IDX_W-1:0] scale_index(input logic [IDX_PROD_W-1:0] prod);
      logic [SCALED_W-1:0] scaled;
      logic [SCALED_W-1:0] shifted;
      scaled  = SCALED_W'(prod) * SCALED_W'(WEIGHT_TABLE_DEPTH);
      shifted = scaled >> 16;
      return (shifted > SCALED_W'(WEIGHT_TABLE_DEPTH - 1)) ?
             IDX_W'(WEIGHT_TABLE_DEPTH - 1) : IDX_W'(shifted);
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [LW_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + (SUM_W + 1)'(b);
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/cwlm_if.sv
// ----------------------------------------------------------------------------
// cwlm interfaces
// Pixel, result and register-write channels, valid/ready each.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwlm_req_if import cwlm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface cwlm_rsp_if import cwlm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] average_luminance;
   modport source (output valid, average_luminance, input ready);
   modport sink   (input valid, average_luminance, output ready);
endinterface

interface cwlm_csr_if import cwlm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/cwlm_ctrl.sv
// ----------------------------------------------------------------------------
// cwlm_ctrl
// Sequencer: steps each pixel through the datapath, runs the divider at
// frame end and owns the result-valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cwlm_ctrl import cwlm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type            state_ff;
   state_type            state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DIV_CNT_W-1:0] div_cnt_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               state_in       = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.calc_product = 1'b1;
            state_in         = ST_INDEX;
         end
         ST_INDEX: begin
            cmd.calc_index = 1'b1;
            state_in       = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.read_table = 1'b1;
            state_in       = ST_WMUL;
         end
         ST_WMUL: begin
            cmd.mul_weight = 1'b1;
            state_in       = ST_WROUND;
         end
         ST_WROUND: begin
            cmd.round_weight = 1'b1;
            state_in         = ST_LWMUL;
         end
         ST_LWMUL: begin
            cmd.mul_luma = 1'b1;
            state_in     = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            state_in       = status.frame_end ? ST_DIV_LOAD : ST_IDLE;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.calc_gain = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> sv/cwlm_dpath.sv
// ----------------------------------------------------------------------------
// cwlm_dpath
// Registers, raster position, luma and weight arithmetic, saturating
// accumulators, restoring divider and output gain.
// ----------------------------------------------------------------------------
`default_nettype none

module cwlm_dpath import cwlm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [PIX_W-1:0]      red,
   input  logic [PIX_W-1:0]      green,
   input  logic [PIX_W-1:0]      blue,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [PIX_W-1:0]      average_luminance
);

   // configuration and frame state
   logic [SIZE_W-1:0] image_width_ff;
   logic [SIZE_W-1:0] image_height_ff;
   logic [STEP_W-1:0] column_step_ff;
   logic [STEP_W-1:0] row_step_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [SUM_W-1:0]  luma_sum_ff;
   logic [SUM_W-1:0]  weight_sum_ff;

   // per-pixel pipeline registers
   logic [PIX_W-1:0]       red_ff;
   logic [PIX_W-1:0]       green_ff;
   logic [PIX_W-1:0]       blue_ff;
   logic                   frame_end_ff;
   logic [OFF_W-1:0]       off_col_ff;
   logic [OFF_W-1:0]       off_row_ff;
   logic [IDX_PROD_W-1:0]  iprod_col_ff;
   logic [IDX_PROD_W-1:0]  iprod_row_ff;
   logic [LUMA_PROD_W-1:0] luma_r_ff;
   logic [LUMA_PROD_W-1:0] luma_g_ff;
   logic [LUMA_PROD_W-1:0] luma_b_ff;
   logic [IDX_W-1:0]       idx_col_ff;
   logic [IDX_W-1:0]       idx_row_ff;
   logic [LUMA_W-1:0]      luma_ff;
   logic [WT_W-1:0]        wc_ff;
   logic [WT_W-1:0]        wr_ff;
   logic [WPROD_W-1:0]     wprod_ff;
   logic [WT_W-1:0]        weight_ff;
   logic [LW_W-1:0]        lw_ff;

   // divider and output
   logic [NUM_W-1:0]       div_num_ff;
   logic [SUM_W-1:0]       div_rem_ff;
   logic [GAIN_PROD_W-1:0] gain_ff;
   logic [PIX_W-1:0]       result_ff;

   logic [SIZE_W-1:0]     width_eff;
   logic [SIZE_W-1:0]     height_eff;
   logic                  col_last;
   logic                  row_last;
   logic [OFF_W-1:0]      off_col_in;
   logic [OFF_W-1:0]      off_row_in;
   logic [LUMA_SUM_W-1:0] luma_total;
   logic [WPROD_W-1:0]    wprod_round;
   logic [SUM_W:0]        rem_shift;
   logic [SUM_W:0]        den_ext;
   logic                  q_bit;
   logic [SUM_W-1:0]      div_rem_in;
   logic [Q_W-1:0]        q_clamped;
   logic [GROUND_W-1:0]   gain_round;
   logic [GROUND_W-1:0]   gain_shift;
   logic [PIX_W-1:0]      result_in;

   always_comb begin
      // out-of-range sizes: zero acts as one, above the maximum as the maximum
      if (image_width_ff == '0) begin
         width_eff = SIZE_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         width_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = SIZE_W'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         height_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         height_eff = image_height_ff;
      end

      col_last   = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(width_eff);
      row_last   = (CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(height_eff);
      off_col_in = doubled_offset(OFF_W'({col_ff, 1'b0}), width_eff);
      off_row_in = doubled_offset(OFF_W'({row_ff, 1'b0}), height_eff);

      luma_total  = LUMA_SUM_W'(luma_r_ff) + LUMA_SUM_W'(luma_g_ff)
                  + LUMA_SUM_W'(luma_b_ff) + LUMA_SUM_W'(32768);
      wprod_round = wprod_ff + WPROD_W'(32768);

      // one restoring-division step per cycle
      rem_shift  = {div_rem_ff, div_num_ff[NUM_W-1]};
      den_ext    = {1'b0, weight_sum_ff};
      q_bit      = (rem_shift >= den_ext);
      div_rem_in = q_bit ? SUM_W'(rem_shift - den_ext) : SUM_W'(rem_shift);

      q_clamped  = (div_num_ff > Q_MAX) ? Q_W'(Q_MAX) : div_num_ff[Q_W-1:0];
      gain_round = GROUND_W'(gain_ff) + GROUND_W'(1 << 19);
      gain_shift = gain_round >> 20;
      if (weight_sum_ff == '0) begin
         result_in = '0;
      end else if (gain_shift > GROUND_W'(65535)) begin
         result_in = '1;
      end else begin
         result_in = PIX_W'(gain_shift);
      end
   end

   // control-side state: registers, raster position, accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIZE_W'(256);
         image_height_ff <= SIZE_W'(256);
         column_step_ff  <= STEP_W'(256);
         row_step_ff     <= STEP_W'(256);
         col_ff          <= '0;
         row_ff          <= '0;
         luma_sum_ff     <= '0;
         weight_sum_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data[SIZE_W-1:0];
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_data[SIZE_W-1:0];
               CSR_COLUMN_STEP:  column_step_ff  <= csr_data[STEP_W-1:0];
               CSR_ROW_STEP:     row_step_ff     <= csr_data[STEP_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.load_pixel) begin
            if (col_last) begin
               col_ff <= '0;
               row_ff <= row_last ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
         if (cmd.accumulate) begin
            luma_sum_ff   <= sat_add(luma_sum_ff, lw_ff);
            weight_sum_ff <= sat_add(weight_sum_ff, LW_W'(weight_ff));
         end
         if (cmd.emit) begin
            luma_sum_ff   <= '0;
            weight_sum_ff <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         red_ff       <= red;
         green_ff     <= green;
         blue_ff      <= blue;
         frame_end_ff <= col_last & row_last;
         off_col_ff   <= off_col_in;
         off_row_ff   <= off_row_in;
      end
      if (cmd.calc_product) begin
         iprod_col_ff <= IDX_PROD_W'(off_col_ff) * IDX_PROD_W'(column_step_ff);
         iprod_row_ff <= IDX_PROD_W'(off_row_ff) * IDX_PROD_W'(row_step_ff);
         luma_r_ff    <= LUMA_PROD_W'(red_ff) * LUMA_PROD_W'(LUMA_R);
         luma_g_ff    <= LUMA_PROD_W'(green_ff) * LUMA_PROD_W'(LUMA_G);
         luma_b_ff    <= LUMA_PROD_W'(blue_ff) * LUMA_PROD_W'(LUMA_B);
      end
      if (cmd.calc_index) begin
         idx_col_ff <= scale_index(iprod_col_ff);
         idx_row_ff <= scale_index(iprod_row_ff);
         luma_ff    <= LUMA_W'(luma_total >> 16);
      end
      if (cmd.read_table) begin
         wc_ff <= WEIGHT_TABLE[idx_col_ff];
         wr_ff <= WEIGHT_TABLE[idx_row_ff];
      end
      if (cmd.mul_weight) begin
         wprod_ff <= WPROD_W'(wc_ff) * WPROD_W'(wr_ff);
      end
      if (cmd.round_weight) begin
         weight_ff <= WT_W'(wprod_round >> 16);
      end
      if (cmd.mul_luma) begin
         lw_ff <= LW_W'(luma_ff) * LW_W'(weight_ff);
      end
      if (cmd.div_load) begin
         div_num_ff <= {luma_sum_ff, 4'b0000};
         div_rem_ff <= '0;
      end
      if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[NUM_W-2:0], q_bit};
         div_rem_ff <= div_rem_in;
      end
      if (cmd.calc_gain) begin
         gain_ff <= GAIN_PROD_W'(q_clamped) * GAIN_PROD_W'(GAIN_Q16);
      end
      if (cmd.emit) begin
         result_ff <= result_in;
      end
   end

   assign status.frame_end  = frame_end_ff;
   assign average_luminance = result_ff;

endmodule

`default_nettype wire

>>> sv/center_weighted_luminance_mean.sv
// ----------------------------------------------------------------------------
// center_weighted_luminance_mean
// Center-weighted average luminance meter: Rec.709 luma of each pixel,
// weighted by a separable Gaussian center weight, averaged over a frame.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake    Payload
// req_bus  in   valid/ready  red, green, blue: 16b unsigned Q4.12 each
// rsp_bus  out  valid/ready  average_luminance: 16b unsigned Q4.12
// csr_bus  in   valid/ready  index 2b, data 16b; ready always high
//
// Pixel transaction: accept plus seven steps through the one shared
//   datapath, which holds a single pixel at a time.
// Frame end: the divider is loaded, the restoring divider runs (one quotient
//   bit per cycle), the gain multiply follows, and then the result register
//   is loaded.
// Reset: synchronous; loads register defaults (256/256/256/256), clears the
//   raster position and both sums. The weight table is constant logic.
// Stalls: the result sits in its own register; pixels of the next frame are
//   taken while it waits, and only the next frame end waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "center_weighted_luminance_mean_macros.svh"

module center_weighted_luminance_mean import cwlm_pkg::*; (
   input logic         clock,
   input logic         reset,
   cwlm_req_if.sink    req_bus,
   cwlm_rsp_if.source  rsp_bus,
   cwlm_csr_if.sink    csr_bus
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   // register writes are always taken; they are to come only while the block is idle, which it does not enforce
   assign csr_bus.ready = 1'b1;

   // sequencer: pixel steps, divider count, result-valid flag
   cwlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, registers, accumulators and result register
   cwlm_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .red               (req_bus.red),
      .green             (req_bus.green),
      .blue              (req_bus.blue),
      .cmd               (cmd),
      .status            (status),
      .average_luminance (rsp_bus.average_luminance)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

   // a result is never loaded over one that is still waiting
   `CWLM_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.emit && rsp_bus.valid, rsp_bus.ready, "result register overwritten")

   // one pixel in flight: no accept right after an accept
   `CWLM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "pixel taken while busy")

   // a new result only appears after the emit step
   `CWLM_ASSERT_IMPLY(a_valid_from_emit, clock, reset, $rose(rsp_bus.valid), $past(cmd.emit), "result valid without emit")

endmodule

`default_nettype wire

>>> dv/center_weighted_luminance_mean_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// center_weighted_luminance_mean_tb
// Streams RGB pixels into the luminance meter under random backpressure on
// both sides and checks each per-frame weighted mean luma against a
// bit-exact fixed-point predictor kept inside this bench. A directed table
// opens the run, then random phases vary frame size, weight steps and
// pixel content.
// ----------------------------------------------------------------------------
module center_weighted_luminance_mean_tb;
   import cwlm_pkg::*;

   localparam real CLOCK_PERIOD   = 4.0;
   localparam int  RESET_CYCLES   = 12;
   localparam int  IDLE_PERCENT   = 23;
   localparam int  SETTLE_CYCLES  = 80;
   localparam int  WATCHDOG_LIMIT = 2000;  // must exceed the long receiver hold-off
   localparam int  RSP_HOLD       = 300;
   localparam int  RANDOM_ITEMS   = 750;
   localparam int  SHOWN_ERRORS   = 10;

   // predictor constants: Rec.709 luma in Q0.16, gain 1.041 in Q1.16
   localparam logic [63:0] RED_Q16    = 64'd13933;
   localparam logic [63:0] GREEN_Q16  = 64'd46872;
   localparam logic [63:0] BLUE_Q16   = 64'd4732;
   localparam logic [63:0] GAIN_1041  = 64'd68223;
   localparam logic [63:0] INV_E_Q32  = 64'd1580030169;
   localparam logic [63:0] ACC_LIMIT  = (64'd1 << 48) - 64'd1;
   localparam int          TABLE_SIZE = 256;
   localparam int          SIZE_LIMIT = 256;

   typedef enum logic {
      ROW_PIXEL,
      ROW_WRITE
   } row_kind_type;

   // reg_sel and value only matter on write rows; pixel fields only on pixel rows
   typedef struct packed {
      row_kind_type  kind;
      csr_index_type reg_sel;
      logic [15:0]   value;
      logic [15:0]   red;
      logic [15:0]   green;
      logic [15:0]   blue;
      logic          fixed;
      logic [15:0]   fixed_mean;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // two pixels of a default 256x256 frame, both far off center
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h1000, 16'h1000, 16'h1000, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h1000, 16'h1000, 16'h1000, 1'b0, 16'd0},
      // shrink to 1x1 mid-frame, zero sizes count as one
      '{ROW_WRITE, CSR_IMAGE_WIDTH,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_WRITE, CSR_IMAGE_HEIGHT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      // column past the new width closes the frame; gray 1.0 -> 4096 * 1.041
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h1000, 16'h1000, 16'h1000, 1'b1, 16'd4264},
      // single-pixel frames: black, saturated white, pure primaries
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'd65535},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 16'd0},
      // 2x1 with the largest steps: every column lands on the last table entry
      '{ROW_WRITE, CSR_IMAGE_WIDTH,  16'h0002, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_WRITE, CSR_COLUMN_STEP,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_WRITE, CSR_ROW_STEP,     16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0},
      // zero weight sum reads as zero
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0},
      // 3x2 with zero steps: flat weights, plain mean
      '{ROW_WRITE, CSR_IMAGE_WIDTH,  16'h0003, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_WRITE, CSR_IMAGE_HEIGHT, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_WRITE, CSR_COLUMN_STEP,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_WRITE, CSR_ROW_STEP,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h0800, 16'h1000, 16'h2000, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h0001, 16'h0002, 16'h0003, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h4000, 16'hC000, 16'h2000, 1'b0, 16'd0},
      '{ROW_PIXEL, CSR_IMAGE_WIDTH,  16'h0000, 16'h1000, 16'h5555, 16'hAAAA, 1'b0, 16'd0}
   };

   logic clock;
   logic reset;

   cwlm_req_if req_bus ();
   cwlm_rsp_if rsp_bus ();
   cwlm_csr_if csr_bus ();

   center_weighted_luminance_mean dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state: register copies, raster position, frame sums
   logic [8:0]  cfg_width;
   logic [8:0]  cfg_height;
   logic [15:0] cfg_col_step;
   logic [15:0] cfg_row_step;
   int unsigned meter_col;
   int unsigned meter_row;
   logic [63:0] luma_acc;
   logic [63:0] weight_acc;
   logic [16:0] center_weight [TABLE_SIZE];

   logic [15:0] expected_means [$];   // frame means still owed by the block
   int          mismatch_count;
   int          stall_cycles;
   int          hold_request;
   int          hold_left;
   bit          steady;                // no idling on either side while set
   bit          need_settle;           // pixels went in since the last drain

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // round(65536 * exp(-x)), x in Q36.28: series for the fraction, 1/e per unit
   function automatic logic [16:0] exp_falloff(input logic [63:0] x_q28);
      logic [63:0] units;
      logic [63:0] frac_q32;
      logic [63:0] term;
      logic [63:0] series;
      logic [63:0] falloff;
      int          n;
      units    = x_q28 >> 28;
      frac_q32 = (x_q28 & 64'h0FFF_FFFF) << 4;
      term     = 64'd1 << 32;
      series   = term;
      for (n = 1; n <= 20; n++) begin
         term   = ((term * frac_q32) >> 32) / 64'(n);
         series = series + term;
      end
      falloff = ((64'd1 << 62) / series) << 2;
      for (n = 0; n < int'(units); n++) begin
         falloff = (falloff * INV_E_Q32 + (64'd1 << 31)) >> 32;
      end
      return 17'((falloff + 64'd32768) >> 16);
   endfunction

   function automatic int unsigned eff_size(input logic [8:0] value);
      if (value == 9'd0) return 1;
      if (int'(value) > SIZE_LIMIT) return SIZE_LIMIT;
      return int'(value);
   endfunction

   function automatic logic [63:0] axis_falloff(input int unsigned pos,
                                                input int unsigned size,
                                                input logic [15:0] step);
      logic [63:0] twice;
      logic [63:0] span;
      logic [63:0] off2;
      logic [63:0] slot;
      twice = 64'(2 * pos);
      span  = 64'(size - 1);
      off2  = (twice >= span) ? twice - span : span - twice;
      slot  = (off2 * 64'(step) * 64'(TABLE_SIZE)) >> 16;
      if (slot > 64'(TABLE_SIZE - 1)) slot = 64'(TABLE_SIZE - 1);
      return 64'(center_weight[slot[7:0]]);
   endfunction

   function automatic logic [63:0] acc_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > ACC_LIMIT) ? ACC_LIMIT : s;
   endfunction

   task automatic meter_pixel(input logic [15:0] red, input logic [15:0] green,
                              input logic [15:0] blue, output bit frame_done,
                              output logic [15:0] mean);
      int unsigned w;
      int unsigned h;
      logic [63:0] luma;
      logic [63:0] weight;
      logic [63:0] quotient;
      logic [63:0] scaled;
      w      = eff_size(cfg_width);
      h      = eff_size(cfg_height);
      luma   = (RED_Q16 * red + GREEN_Q16 * green + BLUE_Q16 * blue + 64'd32768) >> 16;
      weight = (axis_falloff(meter_col, w, cfg_col_step) *
                axis_falloff(meter_row, h, cfg_row_step) + 64'd32768) >> 16;
      luma_acc   = acc_add(luma_acc, luma * weight);
      weight_acc = acc_add(weight_acc, weight);
      frame_done = 1'b0;
      mean       = 16'd0;
      // a position at or past a shrunk size closes the row/frame right here
      if (meter_col + 1 < w) begin
         meter_col++;
      end else begin
         meter_col = 0;
         if (meter_row + 1 < h) begin
            meter_row++;
         end else begin
            meter_row  = 0;
            frame_done = 1'b1;
            if (weight_acc != 64'd0) begin
               quotient = (luma_acc << 4) / weight_acc;
               if (quotient > (64'd1 << 21)) quotient = 64'd1 << 21;
               scaled = (quotient * GAIN_1041 + (64'd1 << 19)) >> 20;
               mean   = (scaled > 64'd65535) ? 16'hFFFF : 16'(scaled);
            end
            luma_acc   = 64'd0;
            weight_acc = 64'd0;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Drivers: everything launched at the falling edge
   // ------------------------------------------------------------------------

   // Drain all owed results, then give the datapath time to finish any pixel
   // that closes no frame. Leaves the pixel channel idle.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (expected_means.size() != 0) @(negedge clock);
      if (need_settle) repeat (SETTLE_CYCLES) @(negedge clock);
      need_settle = 1'b0;
   endtask

   task automatic push_pixel(input logic [15:0] red, input logic [15:0] green,
                             input logic [15:0] blue, input bit fixed,
                             input logic [15:0] fixed_mean);
      bit          done;
      logic [15:0] mean;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.red   <= red;
      req_bus.green <= green;
      req_bus.blue  <= blue;
      do @(posedge clock); while (!req_bus.ready);
      // transaction taken at this edge
      meter_pixel(red, green, blue, done, mean);
      if (done) expected_means.insert(expected_means.size(), fixed ? fixed_mean : mean);
      need_settle = 1'b1;
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [15:0] value);
      if (need_settle) quiesce();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= sel;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (sel)
         CSR_IMAGE_WIDTH:  cfg_width    = value[8:0];
         CSR_IMAGE_HEIGHT: cfg_height   = value[8:0];
         CSR_COLUMN_STEP:  cfg_col_step = value;
         CSR_ROW_STEP:     cfg_row_step = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_channel();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(0, 16'h1FFF));   // up to 2.0
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Result side: ready toggled at the falling edge, checked at the rising
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_means.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
               $display("unexpected result: average_luminance %0d",
                        rsp_bus.average_luminance);
         end else if (expected_means[0] != rsp_bus.average_luminance) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
               $display("mismatch: average_luminance expected %0d, got %0d",
                        expected_means[0], rsp_bus.average_luminance);
            void'(expected_means.pop_front());
         end else begin
            void'(expected_means.pop_front());
         end
      end
   end

   // watchdog: cycles without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int unsigned  row;
      int unsigned  phase;
      int unsigned  burst;
      int unsigned  frame_px;
      int unsigned  random_items;
      int unsigned  k;
      logic [63:0]  x_q28;
      logic [15:0]  r;
      logic [15:0]  g;
      logic [15:0]  b;

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.red   = '0;
      req_bus.green = '0;
      req_bus.blue  = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_IMAGE_WIDTH;
      csr_bus.data  = '0;
      mismatch_count = 0;
      stall_cycles   = 0;
      hold_request   = 0;
      hold_left      = 0;
      steady         = 1'b0;
      need_settle    = 1'b0;

      // weight table: exp(-(4.5 k / depth)^2) with x = 81 k^2 / (4 depth^2)
      for (k = 0; k < TABLE_SIZE; k++) begin
         x_q28 = ((64'd81 * 64'(k) * 64'(k)) << 28) / (64'd4 * 64'(TABLE_SIZE * TABLE_SIZE));
         center_weight[k] = exp_falloff(x_q28);
      end

      // state after reset
      cfg_width    = 9'd256;
      cfg_height   = 9'd256;
      cfg_col_step = 16'd256;
      cfg_row_step = 16'd256;
      meter_col    = 0;
      meter_row    = 0;
      luma_acc     = 64'd0;
      weight_acc   = 64'd0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED[row].kind == ROW_WRITE)
            write_reg(DIRECTED[row].reg_sel, DIRECTED[row].value);
         else
            push_pixel(DIRECTED[row].red, DIRECTED[row].green, DIRECTED[row].blue,
                       DIRECTED[row].fixed, DIRECTED[row].fixed_mean);
      end

      // random phases; every phase boundary drains the block first
      phase        = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         quiesce();
         steady = (random_items >= 250 && random_items < 400);
         burst  = 0;
         if (phase == 2) begin
            // 1x1 frames while the receiver sits out: result register fills,
            // the next frame end backs up into the pixel input
            write_reg(CSR_IMAGE_WIDTH, 16'd1);
            write_reg(CSR_IMAGE_HEIGHT, 16'd1);
            @(posedge clock);
            hold_request = RSP_HOLD;
            @(negedge clock);
            burst = 24;
         end else if (phase == 6) begin
            // one full-width row, width above the maximum
            write_reg(CSR_IMAGE_WIDTH, 16'd511);
            write_reg(CSR_IMAGE_HEIGHT, 16'd1);
            write_reg(CSR_COLUMN_STEP, 16'($urandom_range(64, 512)));
            burst = SIZE_LIMIT;
         end else begin
            if ($urandom_range(0, 99) < 10) begin
               // one axis large: frame stays partial and is cut by a later write
               if ($urandom_range(0, 1) == 0) begin
                  write_reg(CSR_IMAGE_WIDTH, 16'($urandom_range(200, 511)));
                  write_reg(CSR_IMAGE_HEIGHT, 16'($urandom_range(0, 3)));
               end else begin
                  write_reg(CSR_IMAGE_WIDTH, 16'($urandom_range(0, 3)));
                  write_reg(CSR_IMAGE_HEIGHT, 16'($urandom_range(200, 511)));
               end
            end else begin
               if ($urandom_range(0, 3) != 0)
                  write_reg(CSR_IMAGE_WIDTH, 16'($urandom_range(0, 8)));
               if ($urandom_range(0, 3) != 0)
                  write_reg(CSR_IMAGE_HEIGHT, 16'($urandom_range(0, 6)));
            end
            if ($urandom_range(0, 2) != 0)
               write_reg(CSR_COLUMN_STEP, ($urandom_range(0, 3) == 0) ?
                         16'($urandom) : 16'($urandom_range(0, 12000)));
            if ($urandom_range(0, 2) != 0)
               write_reg(CSR_ROW_STEP, ($urandom_range(0, 3) == 0) ?
                         16'($urandom) : 16'($urandom_range(0, 12000)));
         end
         if (burst == 0) begin
            frame_px = eff_size(cfg_width) * eff_size(cfg_height);
            if (frame_px > 64) begin
               burst = $urandom_range(4, 40);
            end else begin
               burst = frame_px * $urandom_range(1, 3);
               // sometimes leave a frame open across the next register write
               if ($urandom_range(0, 2) == 0) burst += $urandom_range(1, frame_px);
            end
         end
         for (k = 0; k < burst; k++) begin
            r = rand_channel();
            if ($urandom_range(0, 4) == 0) begin
               g = r;
               b = r;
            end else begin
               g = rand_channel();
               b = rand_channel();
            end
            push_pixel(r, g, b, 1'b0, 16'd0);
            random_items++;
         end
         phase++;
      end

      steady = 1'b0;
      quiesce();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_means.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
